FILE: hdl/atan2_polynomial_approx_assert.svh
// Assertion macros for the atan2 pipeline top level.
// Used only by atan2_polynomial_approx; expects clk and rst_n in scope.
`ifndef ATAN2_POLYNOMIAL_APPROX_ASSERT_SVH
`define ATAN2_POLYNOMIAL_APPROX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define A2PA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define A2PA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/atan2pa_pkg.sv
// Shared types and constants for the atan2 pipeline.
// No dependencies; imported by atan2pa_div, atan2pa_poly and the top level.
package atan2pa_pkg;

  localparam int A2PA_INPUT_BITS      = 16;
  localparam int A2PA_ANGLE_FRAC_BITS = 13;

  // Fraction bits of the internal ratio and angle words.
  localparam int QB    = 30;
  localparam int Z_W   = QB + 1;  // ratio in [0, 1] at Q0.30
  localparam int ACC_W = 33;      // signed Horner accumulator
  localparam int ANG_W = 35;      // signed angle word after reflection

  localparam int NCOEF = 6;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  // Odd polynomial coefficients at Q2.30, lowest power first.
  localparam acc_t POLY_COEF [NCOEF] = '{
    33'sd1073717407,
    -33'sd357151731,
    33'sd207815708,
    -33'sd125018842,
    33'sd56536073,
    -33'sd12585543
  };

  localparam ang_t HALF_PI_Q30 = 35'sd1686629713;
  localparam ang_t PI_Q30      = 35'sd3373259426;

  // Per-item control bits that ride along with the data.
  typedef struct packed {
    logic zero;   // both coordinates zero
    logic swap;   // |y| > |x|, ratio is |x|/|y|
    logic neg_x;
    logic neg_y;
  } flags_t;

endpackage

FILE: hdl/atan2pa_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on atan2pa_pkg for QB and flags_t.
module atan2pa_div import atan2pa_pkg::*; #(
  parameter int N = A2PA_INPUT_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_v,
  input  logic [N-1:0] in_num,
  input  logic [N-1:0] in_den,
  input  flags_t       in_flags,
  output logic         out_v,
  output logic [QB:0]  out_quo,
  output flags_t       out_flags
);

  localparam int NSTG = QB + 1;

  logic [NSTG-1:0] v_r;
  logic [N-1:0]    rem_r   [NSTG];
  logic [N-1:0]    den_r   [NSTG];
  logic [QB:0]     quo_r   [NSTG];
  flags_t          flags_r [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stage
    logic         src_v;
    logic [N-1:0] src_den;
    logic [QB:0]  src_quo;
    flags_t       src_flags;
    logic [N:0]   trial;
    logic [N:0]   diff;
    logic         ge;
    logic [QB:0]  quo_nxt;
    logic [N-1:0] rem_nxt;

    if (i == 0) begin : g_first
      // The numerator never exceeds the divisor, so the first step needs no shift.
      assign src_v     = in_v;
      assign src_den   = in_den;
      assign src_quo   = '0;
      assign src_flags = in_flags;
      assign trial     = {1'b0, in_num};
    end else begin : g_rest
      assign src_v     = v_r[i-1];
      assign src_den   = den_r[i-1];
      assign src_quo   = quo_r[i-1];
      assign src_flags = flags_r[i-1];
      assign trial     = {rem_r[i-1], 1'b0};
    end

    always_comb begin
      diff    = trial - {1'b0, src_den};
      ge      = (trial >= {1'b0, src_den});
      rem_nxt = ge ? diff[N-1:0] : trial[N-1:0];
      quo_nxt = src_quo;
      quo_nxt[QB-i] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]   <= rem_nxt;
        den_r[i]   <= src_den;
        quo_r[i]   <= quo_nxt;
        flags_r[i] <= src_flags;
      end
    end
  end

  assign out_v     = v_r[NSTG-1];
  assign out_quo   = quo_r[NSTG-1];
  assign out_flags = flags_r[NSTG-1];

endmodule

FILE: hdl/atan2pa_poly.sv
// Odd polynomial arctangent of a Q0.30 ratio: square, five Horner stages, final multiply.
// Depends on atan2pa_pkg for coefficients, widths and flags_t.
module atan2pa_poly import atan2pa_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [Z_W-1:0] in_z,
  input  flags_t         in_flags,
  output logic           out_v,
  output acc_t           out_atan,
  output flags_t         out_flags
);

  localparam int HSTG = NCOEF - 1;

  // Square stage.
  logic           sq_v_r;
  logic [Z_W-1:0] sq_z_r;
  logic [Z_W-1:0] sq_z2_r;
  flags_t         sq_flags_r;
  logic [2*Z_W-1:0] sq_prod;

  assign sq_prod = in_z * in_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else if (en) begin
      sq_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_z_r     <= in_z;
      sq_z2_r    <= sq_prod[QB+Z_W-1:QB];
      sq_flags_r <= in_flags;
    end
  end

  // Horner stages, highest coefficient first.
  logic [HSTG-1:0] h_v_r;
  acc_t            h_acc_r   [HSTG];
  logic [Z_W-1:0]  h_z_r     [HSTG];
  logic [Z_W-1:0]  h_z2_r    [HSTG];
  flags_t          h_flags_r [HSTG];

  for (genvar j = 0; j < HSTG; j++) begin : g_horner
    logic                      src_v;
    acc_t                      src_acc;
    logic [Z_W-1:0]            src_z;
    logic [Z_W-1:0]            src_z2;
    flags_t                    src_flags;
    logic signed [ACC_W+Z_W:0] prod;
    logic signed [ACC_W+Z_W:0] scaled;
    acc_t                      acc_nxt;

    if (j == 0) begin : g_first
      assign src_v     = sq_v_r;
      assign src_acc   = POLY_COEF[NCOEF-1];
      assign src_z     = sq_z_r;
      assign src_z2    = sq_z2_r;
      assign src_flags = sq_flags_r;
    end else begin : g_rest
      assign src_v     = h_v_r[j-1];
      assign src_acc   = h_acc_r[j-1];
      assign src_z     = h_z_r[j-1];
      assign src_z2    = h_z2_r[j-1];
      assign src_flags = h_flags_r[j-1];
    end

    // The arithmetic shift of the signed product rounds toward minus infinity.
    always_comb begin
      prod    = src_acc * $signed({1'b0, src_z2});
      scaled  = prod >>> QB;
      acc_nxt = POLY_COEF[NCOEF-2-j] + scaled[ACC_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        h_v_r[j] <= 1'b0;
      end else if (en) begin
        h_v_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        h_acc_r[j]   <= acc_nxt;
        h_z_r[j]     <= src_z;
        h_z2_r[j]    <= src_z2;
        h_flags_r[j] <= src_flags;
      end
    end
  end

  // Final multiply by the ratio itself.
  logic                      fin_v_r;
  acc_t                      fin_atan_r;
  flags_t                    fin_flags_r;
  logic signed [ACC_W+Z_W:0] fin_prod;
  logic signed [ACC_W+Z_W:0] fin_scaled;

  always_comb begin
    fin_prod   = h_acc_r[HSTG-1] * $signed({1'b0, h_z_r[HSTG-1]});
    fin_scaled = fin_prod >>> QB;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= h_v_r[HSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_atan_r  <= fin_scaled[ACC_W-1:0];
      fin_flags_r <= h_flags_r[HSTG-1];
    end
  end

  assign out_v     = fin_v_r;
  assign out_atan  = fin_atan_r;
  assign out_flags = fin_flags_r;

endmodule

FILE: hdl/atan2pa_skid.sv
// Output register with one skid entry; its ready flag is a register.
// No dependencies.
module atan2pa_skid #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         out_v_r;
  logic [W-1:0] out_d_r;
  logic         skid_v_r;
  logic [W-1:0] skid_d_r;
  logic         take;

  assign take = out_v_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      // Upstream is held while the skid entry is occupied.
      if (take) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !take) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (take) begin
        out_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (out_v_r && !take) begin
        skid_d_r <= push_data;
      end else begin
        out_d_r <= push_data;
      end
    end
  end

  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

endmodule

FILE: hdl/atan2_polynomial_approx.sv
// Four-quadrant arctangent top level: magnitude stage, divider, polynomial,
// reflection and rounding stages, output skid. Depends on atan2pa_pkg and the
// atan2pa_div, atan2pa_poly and atan2pa_skid modules.
//
//   Channel   Dir   Ports                        Contents
//   in_       in    in_tvalid/in_tready/in_tdata  coord_y, coord_x
//   out_      out   out_tvalid/out_tready/out_tdata angle
//
// One request enters per cycle while in_tready is high. With the defaults the
// pipeline has one magnitude stage, one divider stage per quotient bit (31,
// fixed by the Q0.30 ratio), seven polynomial stages, three reflection and
// rounding stages, and the output register. Reset clears only the valid bits.
// When the output is stalled the pipeline still takes one more request into
// the skid entry, then in_tready drops until the skid entry drains.
module atan2_polynomial_approx import atan2pa_pkg::*; #(
  parameter int INPUT_BITS      = A2PA_INPUT_BITS,
  parameter int ANGLE_FRAC_BITS = A2PA_ANGLE_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // [INPUT_BITS-1:0] coord_y, [2*INPUT_BITS-1:INPUT_BITS] coord_x, zero fill above
  input  logic [((2*INPUT_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // [ANGLE_FRAC_BITS+2:0] angle, zero fill above
  output logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0] out_tdata
);

  localparam int N          = INPUT_BITS;
  localparam int ANGLE_BITS = ANGLE_FRAC_BITS + 3;
  localparam int OUT_W      = ((ANGLE_BITS + 7) / 8) * 8;
  localparam int SH         = QB - ANGLE_FRAC_BITS;
  localparam logic [ANG_W-1:0] ROUND_HALF = ANG_W'(64'd1 << (SH - 1));
  localparam logic signed [ANGLE_BITS-1:0] PI_ANGLE =
    ANGLE_BITS'((64'd3373259426 + (64'd1 << (SH - 1))) >> SH);

  logic adv;
  logic skid_full;

  assign adv       = !skid_full;
  assign in_tready = adv;

  // Magnitude and ordering stage.
  logic [N-1:0] coord_y;
  logic [N-1:0] coord_x;
  logic [N-1:0] mag_y;
  logic [N-1:0] mag_x;
  flags_t       f_flags_nxt;
  logic         f_v_r;
  logic [N-1:0] f_num_r;
  logic [N-1:0] f_den_r;
  flags_t       f_flags_r;

  always_comb begin
    coord_y = in_tdata[N-1:0];
    coord_x = in_tdata[2*N-1:N];
    mag_y   = coord_y[N-1] ? (~coord_y + N'(1)) : coord_y;
    mag_x   = coord_x[N-1] ? (~coord_x + N'(1)) : coord_x;
    f_flags_nxt.zero  = (mag_x == '0) && (mag_y == '0);
    f_flags_nxt.swap  = (mag_y > mag_x);
    f_flags_nxt.neg_x = coord_x[N-1];
    f_flags_nxt.neg_y = coord_y[N-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_num_r   <= f_flags_nxt.swap ? mag_x : mag_y;
      f_den_r   <= f_flags_nxt.swap ? mag_y : mag_x;
      f_flags_r <= f_flags_nxt;
    end
  end

  // Ratio of the smaller magnitude to the larger.
  logic        d_v;
  logic [QB:0] d_quo;
  flags_t      d_flags;

  atan2pa_div #(
    .N(N)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_v      (f_v_r),
    .in_num    (f_num_r),
    .in_den    (f_den_r),
    .in_flags  (f_flags_r),
    .out_v     (d_v),
    .out_quo   (d_quo),
    .out_flags (d_flags)
  );

  // Arctangent of the ratio.
  logic   p_v;
  acc_t   p_atan;
  flags_t p_flags;

  atan2pa_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_v      (d_v),
    .in_z      (d_quo),
    .in_flags  (d_flags),
    .out_v     (p_v),
    .out_atan  (p_atan),
    .out_flags (p_flags)
  );

  // Reflection about pi/2 when the ratio was inverted.
  logic   b1_v_r;
  ang_t   b1_a_r;
  flags_t b1_flags_r;
  ang_t   p_atan_w;

  assign p_atan_w = ANG_W'(p_atan);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_a_r     <= p_flags.swap ? (HALF_PI_Q30 - p_atan_w) : p_atan_w;
      b1_flags_r <= p_flags;
    end
  end

  // Reflection about pi for negative x, then clamp at zero.
  logic       b2_v_r;
  logic [ANG_W-1:0] b2_a_r;
  flags_t     b2_flags_r;
  ang_t       b2_a_nxt;

  always_comb begin
    b2_a_nxt = b1_flags_r.neg_x ? (PI_Q30 - b1_a_r) : b1_a_r;
    if (b2_a_nxt < 0) begin
      b2_a_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (adv) begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_a_r     <= b2_a_nxt;
      b2_flags_r <= b1_flags_r;
    end
  end

  // Round the magnitude to the output grid, then apply the sign of y; a zero vector gives a zero angle.
  logic                  b3_v_r;
  logic [ANGLE_BITS-1:0] b3_angle_r;
  logic [ANG_W-1:0]      rsum;
  logic [ANGLE_BITS-1:0] rmag;
  logic [ANGLE_BITS-1:0] b3_angle_nxt;

  always_comb begin
    rsum = b2_a_r + ROUND_HALF;
    rmag = rsum[SH +: ANGLE_BITS];
    if (b2_flags_r.zero) begin
      b3_angle_nxt = '0;
    end else if (b2_flags_r.neg_y) begin
      b3_angle_nxt = ~rmag + ANGLE_BITS'(1);
    end else begin
      b3_angle_nxt = rmag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_v_r <= 1'b0;
    end else if (adv) begin
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_angle_r <= b3_angle_nxt;
    end
  end

  // Output register and skid entry.
  logic [ANGLE_BITS-1:0] out_angle;

  atan2pa_skid #(
    .W(ANGLE_BITS)
  ) u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv && b3_v_r),
    .push_data (b3_angle_r),
    .full      (skid_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_angle)
  );

  assign out_tdata = OUT_W'(out_angle);

  logic signed [ANGLE_BITS-1:0] out_angle_s;
  assign out_angle_s = out_angle;

`include "atan2_polynomial_approx_assert.svh"

  `A2PA_ASSERT_NEXT(a_zero_angle, adv && b2_v_r && b2_flags_r.zero, b3_angle_r == '0, "zero vector did not give a zero angle")
  `A2PA_ASSERT_SAME(a_skid_behind_out, skid_full, out_tvalid, "skid entry holds a request while the output register is empty")
  `A2PA_ASSERT_SAME(a_angle_range, out_tvalid, (out_angle_s <= PI_ANGLE) && (out_angle_s >= -PI_ANGLE), "output angle outside minus pi to pi")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the atan2_polynomial_approx stream block.
// Depends on atan2pa_pkg and the block's RTL; an in-file scoreboard predicts
// every angle in fixed point and checks results in order under random stalls.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W      = atan2pa_pkg::A2PA_INPUT_BITS;
  localparam int FRAC_W    = atan2pa_pkg::A2PA_ANGLE_FRAC_BITS;
  localparam int ANGLE_W   = FRAC_W + 3;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS = 132;

  // Predicts the angle of each accepted pair and checks results in order.
  class angle_scoreboard;
    logic [ANGLE_W-1:0] pending_angles[$];
    int errors = 0;

    // Arctangent of a Q0.30 ratio in [0, 1], returned in Q0.30.
    function longint atan_ratio(longint z);
      longint z2;
      longint acc;
      longint coefs[6];
      coefs = '{64'sd1073717407, -64'sd357151731, 64'sd207815708,
                -64'sd125018842, 64'sd56536073, -64'sd12585543};
      z2 = (z * z) >>> 30;
      acc = coefs[5];
      for (int k = 4; k >= 0; k--) begin
        acc = coefs[k] + ((acc * z2) >>> 30);
      end
      return (acc * z) >>> 30;
    endfunction

    function logic [ANGLE_W-1:0] expected_angle(logic signed [IN_W-1:0] y,
                                                logic signed [IN_W-1:0] x);
      longint ay;
      longint ax;
      longint a;
      longint r;
      ay = (y < 0) ? -longint'(y) : longint'(y);
      ax = (x < 0) ? -longint'(x) : longint'(x);
      if (ax == 0 && ay == 0) begin
        return '0;
      end
      if (ax >= ay) begin
        a = atan_ratio((ay <<< 30) / ax);
      end else begin
        a = 64'sd1686629713 - atan_ratio((ax <<< 30) / ay);
      end
      if (x < 0) begin
        a = 64'sd3373259426 - a;
      end
      if (a < 0) begin
        a = 0;
      end
      // Round the magnitude half up, then apply the sign of y.
      r = (a + (64'sd1 <<< (29 - FRAC_W))) >>> (30 - FRAC_W);
      if (y < 0) begin
        r = -r;
      end
      return r[ANGLE_W-1:0];
    endfunction

    function void note_pair(logic signed [IN_W-1:0] y, logic signed [IN_W-1:0] x);
      pending_angles.push_back(expected_angle(y, x));
    endfunction

    function void check_angle(logic [ANGLE_W-1:0] got);
      logic [ANGLE_W-1:0] want;
      if (pending_angles.size() == 0) begin
        $display("%0t ns: unexpected angle, expected none, actual %0d",
                 $time, $signed(got));
        errors++;
        return;
      end
      want = pending_angles.pop_front();
      if (got !== want) begin
        $display("%0t ns: angle mismatch, expected %0d, actual %0d",
                 $time, $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // [15:0] coord_y, [31:16] coord_x
  logic [2*IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // [15:0] angle
  logic [ANGLE_W-1:0] out_tdata;

  angle_scoreboard angles = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  atan2_polynomial_approx dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: a requested hold-off is counted down here; otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checking and the watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        angles.check_angle(out_tdata);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Offers one pair; in_tvalid is left high so back-to-back pairs need no toggle.
  task automatic send_pair(input logic [IN_W-1:0] y, input logic [IN_W-1:0] x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {x, y};
    do begin
      @(posedge clk);
    end while (!in_tready);
    angles.note_pair(y, x);
    @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] pick_coord();
    case ($urandom_range(9))
      0: return {1'b1, {(IN_W-1){1'b0}}};
      1: return {1'b0, {(IN_W-1){1'b1}}};
      2: return '0;
      3, 4: return IN_W'($signed($urandom_range(64)) - 32);
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [IN_W-1:0] y;
    logic [IN_W-1:0] x;
    for (int i = 0; i < count; i++) begin
      y = pick_coord();
      x = pick_coord();
      // Equal magnitudes take the boundary between the two ratio branches.
      if ($urandom_range(9) == 0) begin
        x = $urandom_range(1) ? y : -y;
      end
      send_pair(y, x);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero vector, the axes, extremes and equal magnitudes.
    send_pair(16'sd0, 16'sd0);
    send_pair(16'sd1, 16'sd0);
    send_pair(-16'sd1, 16'sd0);
    send_pair(16'sd32767, 16'sd0);
    send_pair(-16'sd32768, 16'sd0);
    send_pair(16'sd0, 16'sd1);
    send_pair(16'sd0, -16'sd5);
    send_pair(16'sd0, -16'sd32768);
    send_pair(16'sd0, 16'sd32767);
    send_pair(16'sd32767, 16'sd32767);
    send_pair(-16'sd32768, -16'sd32768);
    send_pair(-16'sd32768, 16'sd32767);
    send_pair(16'sd32767, -16'sd32768);
    send_pair(16'sd1, -16'sd32768);
    send_pair(-16'sd1, -16'sd32768);
    send_pair(-16'sd1, 16'sd32767);
    send_pair(16'sd12345, -16'sd12345);
    send_pair(-16'sd100, 16'sd100);
    send_pair(16'sd1, 16'sd1);
    send_pair(16'sd32767, 16'sd1);
    send_pair(16'sd1, 16'sd32767);
    send_pair(-16'sd32768, -16'sd1);
    send_pair(16'sd2, -16'sd32767);
    send_pair(-16'sd32767, -16'sd2);

    // Random: no idling with one long output hold-off, then idling, stalls, and both.
    hold_left = HOLD_OFF_CYCLES;
    send_random(PHASE_ITEMS);
    send_idle_pct = 50;
    send_random(PHASE_ITEMS);
    send_idle_pct = 0;
    recv_stall_pct = 50;
    send_random(PHASE_ITEMS);
    send_idle_pct = 18;
    recv_stall_pct = 18;
    send_random(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (angles.pending_angles.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (angles.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/atan2pa_pkg.sv
hdl/atan2pa_div.sv
hdl/atan2pa_poly.sv
hdl/atan2pa_skid.sv
hdl/atan2_polynomial_approx.sv
tb/sv/tb_top.sv
